// ===== hw/rtl/rpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpp_pkg
// Shared types and constants of the resource path parser.
// ---------------------------------------------------------------------------
package rpp_pkg;

   localparam int CHAR_W = 8;
   localparam int ID_W   = 16;
   localparam int ACC_W  = 17;
   localparam int OUT_W  = 17;

   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [ID_W-1:0]   MAX_ID_RESET = 16'hFFFF;
   localparam logic [OUT_W-1:0]  ID_NONE      = 17'h1FFFF;

   typedef struct packed {
      logic [1:0]       component_index;
      logic             expect_slash;
      logic [ACC_W-1:0] digit_accumulator;
      logic             seen_digit;
      logic             leading_zero;
      logic             parse_error;
      logic [ID_W-1:0]  first_value;
      logic [ID_W-1:0]  second_value;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      component_index:   2'd0,
      expect_slash:      1'b1,
      digit_accumulator: '0,
      seen_digit:        1'b0,
      leading_zero:      1'b0,
      parse_error:       1'b0,
      first_value:       '0,
      second_value:      '0
   };

   typedef struct packed {
      logic                    path_valid;
      logic [1:0]              component_count;
      logic signed [OUT_W-1:0] object_id;
      logic signed [OUT_W-1:0] instance_id;
      logic signed [OUT_W-1:0] resource_id;
   } verdict_type;

endpackage
`default_nettype wire

// ===== hw/rtl/resource_path_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// resource_path_parser
// Checks a path of the form /A, /A/B or /A/B/C, one character per
// transaction, and returns one verdict transaction per path.
// ---------------------------------------------------------------------------
// Verdict path: the last character is accepted into the input register, then
//   its verdict is loaded into the result register and shown on rsp_tvalid.
// Throughput: one character per cycle unless a verdict waits on rsp_tready.
// Reset (synchronous, active high): clears the parser to the start of a path,
//   empties both registers and sets max_id to 65535.
// ---------------------------------------------------------------------------
module resource_path_parser (
   input  logic        clock,
   input  logic        reset,
   // request: tdata [7:0] char_code; tlast is_last
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // response: tdata [1:0] component_count, [18:2] object_id,
   //   [35:19] instance_id, [52:36] resource_id, [55:53] zero;
   //   tuser [0] path_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,
   // configuration: max_id
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import rpp_pkg::*;

   // limit register
   logic [ID_W-1:0]   max_id_ff,  max_id_in;

   // input register: one character waiting for the parse step
   logic              in_vld_ff,  in_vld_in;
   logic [CHAR_W-1:0] in_char_ff, in_char_in;
   logic              in_last_ff, in_last_in;

   // parser state
   parse_state_type   state_ff,   state_in;
   parse_state_type   state_nxt;

   // result register
   logic              out_vld_ff, out_vld_in;
   verdict_type       out_ff,     out_in;
   verdict_type       verdict;

   logic              out_free;
   logic              step_go;
   logic              req_take;

   rpp_step u_rpp_step (
      .state_cur (state_ff),
      .char_code (in_char_ff),
      .is_last   (in_last_ff),
      .max_id    (max_id_ff),
      .state_nxt (state_nxt),
      .verdict   (verdict)
   );

   // The result register is free when empty or being drained this cycle.
   assign out_free = !out_vld_ff || rsp_tready;
   // A character that makes no verdict never waits on the response side.
   assign step_go  = in_vld_ff && (!in_last_ff || out_free);
   assign req_tready = !in_vld_ff || step_go;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      max_id_in = csr_we ? csr_wdata : max_id_ff;

      // load on acceptance, otherwise drop the slot once it has been parsed
      in_vld_in  = req_take || (in_vld_ff && !step_go);
      in_char_in = req_take ? req_tdata : in_char_ff;
      in_last_in = req_take ? req_tlast : in_last_ff;

      // advance the parser only when the character is consumed
      state_in = step_go ? state_nxt : state_ff;

      // load a verdict on the last character, hold while stalled
      if (step_go && in_last_ff) begin
         out_vld_in = 1'b1;
         out_in     = verdict;
      end else begin
         out_vld_in = out_vld_ff && !rsp_tready;
         out_in     = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_id_ff  <= MAX_ID_RESET;
         in_vld_ff  <= 1'b0;
         state_ff   <= PARSE_STATE_RESET;
         out_vld_ff <= 1'b0;
      end else begin
         max_id_ff  <= max_id_in;
         in_vld_ff  <= in_vld_in;
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.path_valid;
   assign rsp_tdata  = {3'b000, out_ff.resource_id, out_ff.instance_id,
                        out_ff.object_id, out_ff.component_count};

endmodule
`default_nettype wire

// ===== hw/rtl/rpp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpp_step
// Parser update for one character, and the verdict built from the result.
// ---------------------------------------------------------------------------
module rpp_step (
   input  rpp_pkg::parse_state_type  state_cur,
   input  logic [7:0]                char_code,
   input  logic                      is_last,
   input  logic [15:0]               max_id,
   output rpp_pkg::parse_state_type  state_nxt,
   output rpp_pkg::verdict_type      verdict
);
   import rpp_pkg::*;

   parse_state_type  upd;
   logic [CHAR_W-1:0] diff;
   logic [3:0]        digit;
   logic              is_digit;
   logic [19:0]       prod;
   logic              ok;
   logic [OUT_W-1:0]  cur;

   assign diff     = char_code - CHAR_ZERO;
   assign digit    = diff[3:0];
   assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   // times ten as two shifts, plus the digit
   assign prod = {state_cur.digit_accumulator, 3'b000}
               + {2'b00, state_cur.digit_accumulator, 1'b0}
               + {16'd0, digit};

   always_comb begin
      upd = state_cur;
      if (!state_cur.parse_error) begin
         if (char_code == CHAR_SLASH) begin
            if (state_cur.expect_slash) begin
               upd.expect_slash = 1'b0;
            end else if (!state_cur.seen_digit || state_cur.component_index[1]) begin
               upd.parse_error = 1'b1;
            end else begin
               if (state_cur.component_index == 2'd0) begin
                  upd.first_value = state_cur.digit_accumulator[ID_W-1:0];
               end else begin
                  upd.second_value = state_cur.digit_accumulator[ID_W-1:0];
               end
               upd.component_index   = state_cur.component_index + 2'd1;
               upd.digit_accumulator = '0;
               upd.seen_digit        = 1'b0;
               upd.leading_zero      = 1'b0;
            end
         end else if (is_digit) begin
            if (state_cur.expect_slash || state_cur.leading_zero) begin
               upd.parse_error = 1'b1;
            end else begin
               if (!state_cur.seen_digit && (digit == 4'd0)) begin
                  upd.leading_zero = 1'b1;
               end
               upd.seen_digit = 1'b1;
               // saturate one past the limit
               if (prod > {4'd0, max_id}) begin
                  upd.digit_accumulator = {1'b0, max_id} + 17'd1;
                  upd.parse_error       = 1'b1;
               end else begin
                  upd.digit_accumulator = prod[ACC_W-1:0];
               end
            end
         end else begin
            upd.parse_error = 1'b1;
         end
      end
   end

   assign ok  = !upd.parse_error && !upd.expect_slash && upd.seen_digit;
   assign cur = {1'b0, upd.digit_accumulator[ID_W-1:0]};

   always_comb begin
      if (ok) begin
         verdict.path_valid      = 1'b1;
         verdict.component_count = upd.component_index + 2'd1;
         verdict.object_id       = (upd.component_index == 2'd0) ? cur
                                   : {1'b0, upd.first_value};
         verdict.instance_id     = (upd.component_index == 2'd0) ? ID_NONE
                                   : (upd.component_index == 2'd1) ? cur
                                   : {1'b0, upd.second_value};
         verdict.resource_id     = (upd.component_index == 2'd2) ? cur : ID_NONE;
      end else begin
         verdict.path_valid      = 1'b0;
         verdict.component_count = 2'd0;
         verdict.object_id       = ID_NONE;
         verdict.instance_id     = ID_NONE;
         verdict.resource_id     = ID_NONE;
      end
   end

   // return to the start of a path once the verdict is out
   assign state_nxt = is_last ? PARSE_STATE_RESET : upd;

endmodule
`default_nettype wire

// ===== hw/rtl/rpp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rpp_checker
// Port-level checks of the resource path parser, bound to the top level.
// ---------------------------------------------------------------------------
module rpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // failed path reports no components and every ID absent
   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata[1:0] == 2'd0 && rsp_tdata[18:2] == 17'h1FFFF &&
         rsp_tdata[35:19] == 17'h1FFFF && rsp_tdata[52:36] == 17'h1FFFF)
      else $error("failure verdict with stray fields");

   // valid path has a count and a first ID
   a_valid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[1:0] != 2'd0 && rsp_tdata[18] == 1'b0)
      else $error("valid verdict without components");

   // no verdict straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind resource_path_parser rpp_checker u_rpp_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_resource_path_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_resource_path_parser
// Streams resource paths into the parser one character per transaction and
// checks every verdict against a typed one or a cycle-free path checker in the bench.
// A short table of directed paths comes first, then random paths, mostly
// well-formed with random values, some corrupted and some pure noise, over
// several max_id settings. Both sides of the stream idle and stall at random.
// ---------------------------------------------------------------------------
module tb_resource_path_parser;
   import rpp_pkg::*;

   typedef logic [CHAR_W-1:0] char_type;

   // One directed path; want is only used where typed is set.
   typedef struct {
      int          new_max;   // -1 leaves max_id alone
      string       text;      // '#' stands for the byte 0x00
      bit          typed;
      verdict_type want;
   } path_row_type;

   localparam verdict_type REJECTED = '{
      path_valid:      1'b0,
      component_count: 2'd0,
      object_id:       ID_NONE,
      instance_id:     ID_NONE,
      resource_id:     ID_NONE
   };

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 6;      // idle clocks after the last verdict is back
   localparam int RANDOM_CHARS = 1150;
   localparam int PHASES      = 5;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;     // [7:0] char_code
   logic              req_tlast = 1'b0;   // is_last
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [55:0]       rsp_tdata;          // [1:0] count, [18:2] object, [35:19] instance,
                                          // [52:36] resource, [55:53] zero
   logic [0:0]        rsp_tuser;          // [0] path_valid
   logic              csr_we = 1'b0;
   logic [15:0]       csr_wdata = '0;

   // Path checker state, mirrors the block's view of the current path
   logic [1:0]        comp_slot;
   logic              need_slash;
   logic [ACC_W-1:0]  value_acc;
   logic              have_digit;
   logic              zero_lead;
   logic              path_bad;
   logic [ID_W-1:0]   id_first;
   logic [ID_W-1:0]   id_second;
   logic [ID_W-1:0]   limit_id = MAX_ID_RESET;

   verdict_type       pending_verdicts[$];
   char_type          path_buf[$];
   path_row_type      directed[$];
   int                mismatches = 0;
   int                chars_sent = 0;
   int                cycle_count = 0;
   bit                tx_steady = 1'b0;
   bit                rx_steady = 1'b0;
   verdict_type       seen_v;
   verdict_type       want_v;

   resource_path_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run: a hung handshake or a lost verdict ends here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** resource_path_parser: FAILED **");
      $finish;
   end

   function automatic verdict_type good_verdict(input int count, input int a,
                                                input int b, input int c);
      verdict_type v;
      v.path_valid      = 1'b1;
      v.component_count = 2'(count);
      v.object_id       = 17'(a);
      v.instance_id     = 17'(b);
      v.resource_id     = 17'(c);
      return v;
   endfunction

   // Byte for corruption and noise: lean towards slashes and digits so that
   // broken paths still get past the first characters.
   function automatic char_type stray_char();
      case ($urandom_range(0, 3))
         0:       return CHAR_SLASH;
         1:       return CHAR_ZERO + char_type'($urandom_range(0, 9));
         default: return char_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic restart_path();
      comp_slot  = 2'd0;
      need_slash = 1'b1;
      value_acc  = '0;
      have_digit = 1'b0;
      zero_lead  = 1'b0;
      path_bad   = 1'b0;
      id_first   = '0;
      id_second  = '0;
   endtask

   // Advance the path checker by one character; on the last one give the verdict
   // and start a fresh path.
   task automatic parse_char(input char_type c, input logic last,
                             output bit done, output verdict_type v);
      logic [20:0]      grown;
      logic [OUT_W-1:0] cur;
      done = 1'b0;
      v    = REJECTED;
      if (!path_bad) begin
         if (c == CHAR_SLASH) begin
            if (need_slash) begin
               need_slash = 1'b0;
            end else if (!have_digit || comp_slot >= 2'd2) begin
               // empty component or a fourth one
               path_bad = 1'b1;
            end else begin
               if (comp_slot == 2'd0) id_first = value_acc[ID_W-1:0];
               else id_second = value_acc[ID_W-1:0];
               comp_slot  = comp_slot + 2'd1;
               value_acc  = '0;
               have_digit = 1'b0;
               zero_lead  = 1'b0;
            end
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (need_slash || zero_lead) begin
               path_bad = 1'b1;
            end else begin
               if (!have_digit && c == CHAR_ZERO) zero_lead = 1'b1;
               have_digit = 1'b1;
               grown = value_acc * 21'd10 + (c - CHAR_ZERO);
               if (grown > limit_id) begin
                  // saturate one above the limit
                  value_acc = {1'b0, limit_id} + 17'd1;
                  path_bad  = 1'b1;
               end else begin
                  value_acc = grown[ACC_W-1:0];
               end
            end
         end else begin
            path_bad = 1'b1;
         end
      end
      if (last) begin
         done = 1'b1;
         if (!path_bad && !need_slash && have_digit) begin
            cur = {1'b0, value_acc[ID_W-1:0]};
            v.path_valid      = 1'b1;
            v.component_count = comp_slot + 2'd1;
            v.object_id       = (comp_slot == 2'd0) ? cur : {1'b0, id_first};
            v.instance_id     = (comp_slot == 2'd0) ? ID_NONE
                              : (comp_slot == 2'd1) ? cur : {1'b0, id_second};
            v.resource_id     = (comp_slot == 2'd2) ? cur : ID_NONE;
         end
         restart_path();
      end
   endtask

   // Drive one character transaction. Entered and left at a falling edge; the
   // verdict is queued at the accepting edge, ahead of its earliest arrival.
   task automatic send_char(input char_type c, input logic last,
                            input bit typed, input verdict_type given);
      int          gap;
      bit          done;
      verdict_type v;
      gap = tx_steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      parse_char(c, last, done, v);
      if (done) pending_verdicts.push_back(typed ? given : v);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_path(input bit typed, input verdict_type given);
      for (int i = 0; i < path_buf.size(); i++)
         send_char(path_buf[i], i == path_buf.size() - 1, typed, given);
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++)
         path_buf.push_back((s[i] == "#") ? 8'h00 : s[i]);
   endtask

   // Hold off the sender until every verdict is back and the pipe is empty.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_max_id(input logic [ID_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      limit_id   = value;
   endtask

   // Result side: stall for a random number of cycles, then take one verdict.
   initial begin : response_side
      int stall;
      @(negedge reset);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Compare each accepted verdict with the oldest one queued.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_v.path_valid      = rsp_tuser[0];
         seen_v.component_count = rsp_tdata[1:0];
         seen_v.object_id       = rsp_tdata[18:2];
         seen_v.instance_id     = rsp_tdata[35:19];
         seen_v.resource_id     = rsp_tdata[52:36];
         if (pending_verdicts.size() == 0) begin
            $display("%0t: verdict with none expected: valid %0b count %0d ids %0d %0d %0d",
                     $time, seen_v.path_valid, seen_v.component_count,
                     seen_v.object_id, seen_v.instance_id, seen_v.resource_id);
            mismatches++;
         end else begin
            want_v = pending_verdicts.pop_front();
            if (seen_v.path_valid !== want_v.path_valid) begin
               $display("%0t: path_valid expected %0b, got %0b",
                        $time, want_v.path_valid, seen_v.path_valid);
               mismatches++;
            end
            if (seen_v.component_count !== want_v.component_count) begin
               $display("%0t: component_count expected %0d, got %0d",
                        $time, want_v.component_count, seen_v.component_count);
               mismatches++;
            end
            if (seen_v.object_id !== want_v.object_id) begin
               $display("%0t: object_id expected %0d, got %0d",
                        $time, want_v.object_id, seen_v.object_id);
               mismatches++;
            end
            if (seen_v.instance_id !== want_v.instance_id) begin
               $display("%0t: instance_id expected %0d, got %0d",
                        $time, want_v.instance_id, seen_v.instance_id);
               mismatches++;
            end
            if (seen_v.resource_id !== want_v.resource_id) begin
               $display("%0t: resource_id expected %0d, got %0d",
                        $time, want_v.resource_id, seen_v.resource_id);
               mismatches++;
            end
         end
      end
   end

   initial begin : request_side
      int          target;
      int          n;
      int          value;
      int          pos;
      int          kind;
      logic [15:0] phase_max;
      verdict_type none_given;

      none_given = REJECTED;
      restart_path();

      // Directed paths. Typed verdicts are the ones that read straight off the
      // path; the rest go through the checker.
      directed.push_back(path_row_type'{-1, "/0", 1'b1, good_verdict(1, 0, -1, -1)});
      directed.push_back(path_row_type'{-1, "/65535/0/1", 1'b1, good_verdict(3, 65535, 0, 1)});
      directed.push_back(path_row_type'{-1, "/7/42", 1'b0, REJECTED});
      directed.push_back(path_row_type'{-1, "/65536", 1'b1, REJECTED});      // too large
      directed.push_back(path_row_type'{-1, "/99999999/1", 1'b1, REJECTED}); // saturate, then skip
      directed.push_back(path_row_type'{-1, "/01", 1'b1, REJECTED});         // leading zero
      directed.push_back(path_row_type'{-1, "/00", 1'b1, REJECTED});
      directed.push_back(path_row_type'{-1, "//1", 1'b1, REJECTED});         // empty component
      directed.push_back(path_row_type'{-1, "/", 1'b1, REJECTED});
      directed.push_back(path_row_type'{-1, "/1/2/3/4", 1'b1, REJECTED});    // fourth component
      directed.push_back(path_row_type'{-1, "/1/2/", 1'b1, REJECTED});       // trailing slash
      directed.push_back(path_row_type'{-1, "/1#2", 1'b1, REJECTED});        // NUL byte
      directed.push_back(path_row_type'{-1, "/-1", 1'b1, REJECTED});         // sign
      directed.push_back(path_row_type'{-1, "/1\377", 1'b1, REJECTED});      // top byte
      directed.push_back(path_row_type'{-1, "12", 1'b1, REJECTED});          // no opening slash
      directed.push_back(path_row_type'{0, "/0/0/0", 1'b1, good_verdict(3, 0, 0, 0)});
      directed.push_back(path_row_type'{-1, "/1", 1'b1, REJECTED});
      directed.push_back(path_row_type'{100, "/100/99", 1'b0, REJECTED});
      directed.push_back(path_row_type'{-1, "/101", 1'b1, REJECTED});
      directed.push_back(path_row_type'{-1, "/9/100/3", 1'b0, REJECTED});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[r]) begin
         if (directed[r].new_max >= 0) write_max_id(16'(directed[r].new_max));
         path_buf.delete();
         load_text(directed[r].text);
         send_path(directed[r].typed, directed[r].want);
      end

      // Random paths, one max_id setting per phase, extremes included.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       phase_max = MAX_ID_RESET;
            1:       phase_max = 16'd0;
            2:       phase_max = 16'($urandom_range(1, 65534));
            3:       phase_max = 16'd9;
            default: phase_max = 16'd65534;
         endcase
         write_max_id(phase_max);
         target = chars_sent + RANDOM_CHARS / PHASES;
         while (chars_sent < target) begin
            if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
            if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
            if ($urandom_range(0, 39) == 0) drain();
            path_buf.delete();
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
               // well-formed path with random values
               n = $urandom_range(1, 3);
               repeat (n) begin
                  case ($urandom_range(0, 7))
                     0:       value = 0;
                     1:       value = limit_id;
                     2:       value = limit_id + 1;
                     3:       value = $urandom_range(0, 9);
                     4:       value = $urandom_range(0, 65535);
                     5:       value = $urandom_range(65536, 999999);
                     default: value = $urandom_range(0, limit_id);
                  endcase
                  load_text($sformatf("/%0d", value));
               end
               // break a share of them
               if (kind >= 5) begin
                  pos = $urandom_range(0, path_buf.size() - 1);
                  case ($urandom_range(0, 5))
                     0: path_buf.insert(pos, stray_char());
                     1: if (path_buf.size() > 1) path_buf.delete(pos);
                     2: path_buf.push_back(CHAR_SLASH);
                     3: load_text($sformatf("/%0d", $urandom_range(0, 99)));
                     4: path_buf[pos] = stray_char();
                     default: path_buf.insert(1, CHAR_ZERO);
                  endcase
               end
            end else begin
               repeat ($urandom_range(1, 8)) path_buf.push_back(stray_char());
            end
            send_path(1'b0, none_given);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("** resource_path_parser: PASSED **");
      end else begin
         $display("** resource_path_parser: FAILED **");
      end
      $finish;
   end

endmodule
